// ----- rtl/core/dwaa_pkg.sv -----
package dwaa_pkg;

	localparam int ID_W   = 5;
	localparam int WT_W   = 8;
	localparam int LOAD_W = 10;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [WT_W-1:0]   wt_t;
	typedef logic [LOAD_W-1:0] load_t;
	typedef logic [LOAD_W:0]   sum_t;
	typedef logic [1:0]        status_t;

	localparam load_t MAX_WEIGHT_RESET = 10'd201;

	localparam logic OP_ENTER = 1'b0;
	localparam logic OP_EXIT  = 1'b1;

	localparam logic DIR_SOUTH = 1'b1;

	localparam status_t STATUS_GRANT = 2'd0;
	localparam status_t STATUS_WAIT  = 2'd1;
	localparam status_t STATUS_DROP  = 2'd2;

	typedef struct packed {
		id_t  id;
		logic dir;
		wt_t  wt;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FINISH
	} state_t;

endpackage

// ----- rtl/core/dwaa_if.sv -----
interface dwaa_req_if;
	logic              valid;
	logic              ready;
	logic              opcode;
	dwaa_pkg::id_t     requester_id;
	logic              direction;
	dwaa_pkg::wt_t     weight;

	modport source (output valid, opcode, requester_id, direction, weight, input ready);
	modport sink (input valid, opcode, requester_id, direction, weight, output ready);
endinterface

interface dwaa_res_if;
	logic              valid;
	logic              ready;
	dwaa_pkg::id_t     grant_id;
	dwaa_pkg::status_t status;
	logic              last;

	modport source (output valid, grant_id, status, last, input ready);
	modport sink (input valid, grant_id, status, last, output ready);
endinterface

// ----- rtl/core/dwaa_queue_ram.sv -----
module dwaa_queue_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 14,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/direction_weight_admission_arbiter.sv -----
// Admission control for a one-lane resource shared by two directions.
// req channel: one transfer per enter request (opcode 0) or exit notice
// (opcode 1) with requester_id, direction and weight.
// res channel: result transfers with grant_id, status (grant, wait, drop)
// and last on the final result of each request.
// cfg_we / cfg_wdata write max_weight; a grant joining the current
// direction keeps total load strictly below it; a switch onto an empty
// lane admits any weight. Enter: its single result sits in the output
// register the next cycle; a new request is taken once it leaves.
// Exit: idle if the queue is empty, else an eval walk, then finish.
// The wait queue lives in a single-port-read RAM and is walked one entry
// per cycle, compacting the remaining entries in place; each grant found
// during the walk leaves through a one-deep hold register so that the last
// flag can be set on the final one. An exit that grants nothing returns no
// result.
// Backpressure on res holds the walk whenever a grant finds the output
// register and hold register both occupied; no result is lost.
// Reset (arst_n low): direction south, load zero, queue empty, max_weight
// 201. Queue contents are not cleared; only entries below the count are read.
module direction_weight_admission_arbiter #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  dwaa_pkg::load_t     cfg_wdata,
	dwaa_req_if.sink            req,
	dwaa_res_if.source          res
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	dwaa_pkg::state_t  state_q, state_d;
	logic              dir_q;
	dwaa_pkg::load_t   load_q;
	dwaa_pkg::load_t   max_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  r_q;
	logic [CNT_W-1:0]  w_q;
	logic              pend_v_q;
	dwaa_pkg::id_t     pend_id_q;
	logic              res_valid_q;
	dwaa_pkg::id_t     res_id_q;
	dwaa_pkg::status_t res_status_q;
	logic              res_last_q;

	logic              out_free;
	logic              acc;
	logic              is_enter;
	dwaa_pkg::sum_t    enter_sum;
	logic              enter_fits;
	logic              enter_switch;
	logic              enter_room;
	dwaa_pkg::load_t   exit_load;
	logic              exit_flip;
	dwaa_pkg::entry_t  entry;
	dwaa_pkg::sum_t    entry_sum;
	logic              entry_fits;
	logic              advance;
	logic              last_entry;
	logic              finish_go;
	logic              res_load;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	dwaa_pkg::entry_t  mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	logic [$bits(dwaa_pkg::entry_t)-1:0] mem_rdata;
	dwaa_pkg::entry_t  req_entry;

	dwaa_queue_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH ($bits(dwaa_pkg::entry_t))
	) u_queue (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign entry = dwaa_pkg::entry_t'(mem_rdata);

	assign req_entry.id  = req.requester_id;
	assign req_entry.dir = req.direction;
	assign req_entry.wt  = req.weight;

	assign out_free = !res_valid_q || res.ready;
	assign req.ready = (state_q == dwaa_pkg::ST_IDLE) && out_free;
	assign acc = req.valid && req.ready;
	assign is_enter = (req.opcode == dwaa_pkg::OP_ENTER);

	assign enter_sum = {1'b0, load_q} + dwaa_pkg::sum_t'(req.weight);
	assign enter_fits = (req.direction == dir_q) && (enter_sum < {1'b0, max_q});
	assign enter_switch = (req.direction != dir_q) && (load_q == '0);
	assign enter_room = (count_q != CNT_W'(QUEUE_DEPTH));

	assign exit_load = (load_q >= dwaa_pkg::load_t'(req.weight)) ?
		load_q - dwaa_pkg::load_t'(req.weight) : '0;
	assign exit_flip = (exit_load == '0) && (count_q != '0);

	assign entry_sum = {1'b0, load_q} + dwaa_pkg::sum_t'(entry.wt);
	assign entry_fits = (entry.dir == dir_q) && (entry_sum < {1'b0, max_q});
	assign last_entry = (CNT_W'(r_q) + CNT_W'(1)) == count_q;
	assign finish_go = !pend_v_q || out_free;

	assign res_load = ((state_q == dwaa_pkg::ST_IDLE) && acc && is_enter) ||
		((state_q == dwaa_pkg::ST_EVAL) && advance && entry_fits && pend_v_q) ||
		((state_q == dwaa_pkg::ST_FINISH) && finish_go && pend_v_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dwaa_pkg::ST_IDLE: begin
				if (acc && !is_enter && count_q != '0) begin
					state_d = dwaa_pkg::ST_EVAL;
				end
			end
			dwaa_pkg::ST_EVAL: begin
				if (advance && last_entry) begin
					state_d = dwaa_pkg::ST_FINISH;
				end
			end
			dwaa_pkg::ST_FINISH: begin
				if (finish_go) begin
					state_d = dwaa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dwaa_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		advance   = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = req_entry;
		mem_raddr = '0;
		case (state_q)
			dwaa_pkg::ST_IDLE: begin
				mem_we = acc && is_enter && !enter_fits && !enter_switch && enter_room;
			end
			dwaa_pkg::ST_EVAL: begin
				advance   = !(entry_fits && pend_v_q && !out_free);
				mem_raddr = advance ? r_q + IDX_W'(1) : r_q;
				mem_we    = advance && !entry_fits;
				mem_waddr = w_q[IDX_W-1:0];
				mem_wdata = entry;
			end
			default: begin
				mem_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dwaa_pkg::ST_IDLE;
			dir_q       <= dwaa_pkg::DIR_SOUTH;
			load_q      <= '0;
			max_q       <= dwaa_pkg::MAX_WEIGHT_RESET;
			count_q     <= '0;
			r_q         <= '0;
			w_q         <= '0;
			pend_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				dwaa_pkg::ST_IDLE: begin
					if (acc && is_enter) begin
						if (enter_fits) begin
							load_q <= enter_sum[dwaa_pkg::LOAD_W-1:0];
						end else if (enter_switch) begin
							dir_q  <= req.direction;
							load_q <= dwaa_pkg::load_t'(req.weight);
						end else if (enter_room) begin
							count_q <= count_q + CNT_W'(1);
						end
					end else if (acc) begin
						load_q <= exit_load;
						if (exit_flip) begin
							dir_q <= !dir_q;
						end
						r_q <= '0;
						w_q <= '0;
					end
				end
				dwaa_pkg::ST_EVAL: begin
					if (advance) begin
						r_q <= r_q + IDX_W'(1);
						if (entry_fits) begin
							load_q   <= entry_sum[dwaa_pkg::LOAD_W-1:0];
							pend_v_q <= 1'b1;
						end else begin
							w_q <= w_q + CNT_W'(1);
						end
					end
				end
				dwaa_pkg::ST_FINISH: begin
					if (finish_go) begin
						count_q  <= w_q;
						pend_v_q <= 1'b0;
					end
				end
				default: begin
					pend_v_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dwaa_pkg::ST_IDLE: begin
				if (acc && is_enter) begin
					res_id_q   <= req.requester_id;
					res_last_q <= 1'b1;
					if (enter_fits || enter_switch) begin
						res_status_q <= dwaa_pkg::STATUS_GRANT;
					end else if (enter_room) begin
						res_status_q <= dwaa_pkg::STATUS_WAIT;
					end else begin
						res_status_q <= dwaa_pkg::STATUS_DROP;
					end
				end
			end
			dwaa_pkg::ST_EVAL: begin
				if (advance && entry_fits) begin
					pend_id_q <= entry.id;
					if (pend_v_q) begin
						res_id_q     <= pend_id_q;
						res_status_q <= dwaa_pkg::STATUS_GRANT;
						res_last_q   <= 1'b0;
					end
				end
			end
			dwaa_pkg::ST_FINISH: begin
				if (pend_v_q && out_free) begin
					res_id_q     <= pend_id_q;
					res_status_q <= dwaa_pkg::STATUS_GRANT;
					res_last_q   <= 1'b1;
				end
			end
			default: begin
				pend_id_q <= pend_id_q;
			end
		endcase
	end

	assign res.valid    = res_valid_q;
	assign res.grant_id = res_id_q;
	assign res.status   = res_status_q;
	assign res.last     = res_last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dwaa_pkg::ST_IDLE) |-> !pend_v_q)
		else $error("held grant left over in idle");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dwaa_pkg::ST_EVAL) |-> (w_q <= CNT_W'(r_q)))
		else $error("write pointer ahead of read pointer");

	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> out_free)
		else $error("request taken while output register busy");
`endif

endmodule

// ----- verif/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   QUEUE_DEPTH = 32;
	localparam int   SETTLE      = 50;
	localparam int   HOLD_OFF    = 300;
	localparam logic DIR_NORTH   = ~dwaa_pkg::DIR_SOUTH;

	typedef struct packed {
		dwaa_pkg::id_t     id;
		dwaa_pkg::status_t status;
		logic              last;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	dwaa_pkg::load_t cfg_wdata;

	dwaa_req_if req_ch ();
	dwaa_res_if res_ch ();

	direction_weight_admission_arbiter #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.res      (res_ch)
	);

	logic              lane_dir;
	int                lane_load;
	int                lane_limit;
	dwaa_pkg::entry_t  queued_requests[$];
	int                riders[$];
	verdict_t          admission_verdicts[$];

	int error_count;
	bit tx_busy;
	bit rx_busy;
	bit hold_off_req;
	int rx_wait;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int idle_draw(bit busy);
		if (!busy || $urandom_range(0, 3) == 0)
			return 0;
		return int'($urandom_range(0, 17));
	endfunction

	function automatic void push_verdict(dwaa_pkg::id_t id, dwaa_pkg::status_t status,
		logic last);
		verdict_t v;
		v.id = id;
		v.status = status;
		v.last = last;
		admission_verdicts.insert(admission_verdicts.size(), v);
	endfunction

	function automatic void predict_admission(logic op, dwaa_pkg::id_t id, logic dir,
		dwaa_pkg::wt_t wt);
		dwaa_pkg::entry_t kept[$];
		dwaa_pkg::entry_t e;
		int granted;
		granted = 0;
		if (op == dwaa_pkg::OP_ENTER) begin
			if (dir == lane_dir && lane_load + int'(wt) < lane_limit) begin
				lane_load += int'(wt);
				riders.insert(riders.size(), int'(wt));
				push_verdict(id, dwaa_pkg::STATUS_GRANT, 1'b1);
			end else if (dir != lane_dir && lane_load == 0) begin
				lane_dir = dir;
				lane_load = int'(wt);
				riders.delete();
				riders.insert(riders.size(), int'(wt));
				push_verdict(id, dwaa_pkg::STATUS_GRANT, 1'b1);
			end else if (queued_requests.size() < QUEUE_DEPTH) begin
				e.id = id;
				e.dir = dir;
				e.wt = wt;
				queued_requests.insert(queued_requests.size(), e);
				push_verdict(id, dwaa_pkg::STATUS_WAIT, 1'b1);
			end else begin
				push_verdict(id, dwaa_pkg::STATUS_DROP, 1'b1);
			end
		end else begin
			lane_load = (lane_load >= int'(wt)) ? lane_load - int'(wt) : 0;
			if (lane_load == 0)
				riders.delete();
			if (lane_load == 0 && queued_requests.size() != 0)
				lane_dir = ~lane_dir;
			foreach (queued_requests[i]) begin
				e = queued_requests[i];
				if (e.dir == lane_dir && lane_load + int'(e.wt) < lane_limit) begin
					lane_load += int'(e.wt);
					riders.insert(riders.size(), int'(e.wt));
					push_verdict(e.id, dwaa_pkg::STATUS_GRANT, 1'b0);
					granted++;
				end else begin
					kept.insert(kept.size(), e);
				end
			end
			queued_requests = kept;
			if (granted > 0)
				admission_verdicts[admission_verdicts.size() - 1].last = 1'b1;
		end
		lane_load &= 'h3FF;
	endfunction

	task automatic send_item(logic op, dwaa_pkg::id_t id, logic dir, dwaa_pkg::wt_t wt);
		int gap;
		gap = idle_draw(tx_busy);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.requester_id <= id;
		req_ch.direction <= dir;
		req_ch.weight <= wt;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predict_admission(op, id, dir, wt);
	endtask

	task automatic quiesce();
		req_ch.valid <= 1'b0;
		while (admission_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_limit(dwaa_pkg::load_t value);
		quiesce();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		lane_limit = int'(value);
	endtask

	task automatic check_result();
		verdict_t v;
		if (admission_verdicts.size() == 0) begin
			$error("unexpected result grant_id=%0d status=%0d last=%0d",
				res_ch.grant_id, res_ch.status, res_ch.last);
			error_count++;
		end else begin
			v = admission_verdicts.pop_front();
			if (res_ch.grant_id !== v.id) begin
				$error("grant_id expected %0d actual %0d", v.id, res_ch.grant_id);
				error_count++;
			end
			if (res_ch.status !== v.status) begin
				$error("status expected %0d actual %0d", v.status, res_ch.status);
				error_count++;
			end
			if (res_ch.last !== v.last) begin
				$error("last expected %0d actual %0d", v.last, res_ch.last);
				error_count++;
			end
		end
	endtask

	// result receiver
	initial begin
		res_ch.ready = 1'b0;
		rx_wait = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				check_result();
				rx_wait = idle_draw(rx_busy);
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rx_wait = HOLD_OFF;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// empty the lane and the wait queue; needs a limit above any single weight
	task automatic drain_lane();
		while (queued_requests.size() != 0 || lane_load != 0)
			send_item(dwaa_pkg::OP_EXIT, dwaa_pkg::id_t'($urandom_range(0, 31)),
				1'($urandom_range(0, 1)), 8'd255);
	endtask

	task automatic test_lane_basics();
		send_item(dwaa_pkg::OP_ENTER, 5'd1, dwaa_pkg::DIR_SOUTH, 8'd100);
		send_item(dwaa_pkg::OP_ENTER, 5'd2, dwaa_pkg::DIR_SOUTH, 8'd100);
		send_item(dwaa_pkg::OP_ENTER, 5'd3, dwaa_pkg::DIR_SOUTH, 8'd1);
		send_item(dwaa_pkg::OP_ENTER, 5'd4, DIR_NORTH, 8'd5);
		send_item(dwaa_pkg::OP_EXIT, 5'd31, DIR_NORTH, 8'd255);
		send_item(dwaa_pkg::OP_EXIT, 5'd0, dwaa_pkg::DIR_SOUTH, 8'd5);
		send_item(dwaa_pkg::OP_EXIT, 5'd0, dwaa_pkg::DIR_SOUTH, 8'd1);
	endtask

	task automatic test_direction_switch();
		send_item(dwaa_pkg::OP_ENTER, 5'd31, DIR_NORTH, 8'd255);
		send_item(dwaa_pkg::OP_ENTER, 5'd0, DIR_NORTH, 8'd0);
		send_item(dwaa_pkg::OP_EXIT, 5'd10, DIR_NORTH, 8'd255);
		send_item(dwaa_pkg::OP_ENTER, 5'd7, dwaa_pkg::DIR_SOUTH, 8'd250);
		send_item(dwaa_pkg::OP_EXIT, 5'd11, dwaa_pkg::DIR_SOUTH, 8'd1);
		send_item(dwaa_pkg::OP_EXIT, 5'd12, DIR_NORTH, 8'd1);
	endtask

	task automatic test_queue_full();
		set_limit(10'd1);
		for (int i = 0; i < QUEUE_DEPTH + 4; i++)
			send_item(dwaa_pkg::OP_ENTER, i[4:0], i[0], 8'd1 + i[7:0]);
		set_limit(10'd1023);
		drain_lane();
	endtask

	task automatic test_mass_release();
		logic side;
		drain_lane();
		side = lane_dir;
		send_item(dwaa_pkg::OP_ENTER, 5'd30, side, 8'd10);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_item(dwaa_pkg::OP_ENTER, i[4:0], ~side, 8'd1);
		send_item(dwaa_pkg::OP_ENTER, 5'd31, ~side, 8'd1);
		send_item(dwaa_pkg::OP_EXIT, 5'd30, side, 8'd10);
		drain_lane();
	endtask

	task automatic test_backpressure();
		quiesce();
		tx_busy = 1'b0;
		hold_off_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_item(dwaa_pkg::OP_ENTER, dwaa_pkg::id_t'($urandom_range(0, 31)),
				1'($urandom_range(0, 1)), dwaa_pkg::wt_t'($urandom_range(1, 255)));
		send_item(dwaa_pkg::OP_EXIT, 5'd0, dwaa_pkg::DIR_SOUTH, 8'd255);
		tx_busy = 1'b1;
		drain_lane();
	endtask

	task automatic run_traffic(int count);
		int idx;
		int cap;
		dwaa_pkg::wt_t wt;
		for (int i = 0; i < count; i++) begin
			if (i % 20 == 0) begin
				tx_busy = 1'($urandom_range(0, 1));
				rx_busy = 1'($urandom_range(0, 1));
			end
			if ($urandom_range(0, 99) < 55) begin
				cap = lane_limit / 3;
				if (cap < 1)
					cap = 1;
				if (cap > 255)
					cap = 255;
				if ($urandom_range(0, 9) < 6)
					wt = dwaa_pkg::wt_t'($urandom_range(1, cap));
				else
					wt = dwaa_pkg::wt_t'($urandom_range(1, 255));
				send_item(dwaa_pkg::OP_ENTER, dwaa_pkg::id_t'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)), wt);
			end else begin
				if (riders.size() > 0 && $urandom_range(0, 9) < 8) begin
					idx = int'($urandom_range(0, riders.size() - 1));
					wt = dwaa_pkg::wt_t'(riders[idx]);
					riders.delete(idx);
				end else begin
					wt = dwaa_pkg::wt_t'($urandom_range(1, 255));
				end
				send_item(dwaa_pkg::OP_EXIT, dwaa_pkg::id_t'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)), wt);
			end
		end
	endtask

	task automatic test_random_traffic();
		set_limit(dwaa_pkg::MAX_WEIGHT_RESET);
		run_traffic(60);
		set_limit(10'd1023);
		run_traffic(60);
		set_limit(10'd1);
		run_traffic(40);
		set_limit(dwaa_pkg::load_t'($urandom_range(2, 1022)));
		run_traffic(50);
		set_limit(dwaa_pkg::load_t'($urandom_range(100, 600)));
		run_traffic(50);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = dwaa_pkg::OP_ENTER;
		req_ch.requester_id = '0;
		req_ch.direction = dwaa_pkg::DIR_SOUTH;
		req_ch.weight = '0;
		lane_dir = dwaa_pkg::DIR_SOUTH;
		lane_load = 0;
		lane_limit = int'(dwaa_pkg::MAX_WEIGHT_RESET);
		error_count = 0;
		tx_busy = 1'b1;
		rx_busy = 1'b1;
		hold_off_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lane_basics();
		test_direction_switch();
		test_queue_full();
		test_mass_release();
		test_backpressure();
		test_random_traffic();

		quiesce();
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
